// ===== rtl/multichannel_conv2d_4x4_assert.svh =====
// Assertion macros for the convolution RTL, included by the queue module.
`ifndef MULTICHANNEL_CONV2D_4X4_ASSERT_SVH
`define MULTICHANNEL_CONV2D_4X4_ASSERT_SVH

`ifndef SYNTH

// Check cons in the same cycle whenever ante holds.
`define MC4_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check cons in the cycle after ante holds.
`define MC4_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define MC4_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define MC4_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/mc4_pkg.sv =====
// Shared types and constants of the multichannel 4x4 convolution block.
package mc4_pkg;

  localparam int KSIZE = 4;
  localparam int NCHAN = 3;
  localparam int SAMPLE_W = 8;
  localparam int PIX_W = NCHAN * SAMPLE_W;
  localparam int WEIGHT_REG_W = KSIZE * 8;
  localparam int SUM_W = 22;
  localparam int PROD_W = 17;
  localparam int QDEPTH = 4;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int DEF_IMAGE_WIDTH = 16;
  localparam int DEF_IMAGE_HEIGHT = 24;

  // Configuration register indexes.
  localparam logic [1:0] REG_WEIGHTS_ROW0 = 2'd0;
  localparam logic [1:0] REG_WEIGHTS_ROW1 = 2'd1;
  localparam logic [1:0] REG_WEIGHTS_ROW2 = 2'd2;
  localparam logic [1:0] REG_WEIGHTS_ROW3 = 2'd3;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [4:0] orow_t;
  typedef logic [3:0] ocol_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // [row][tap], row 0 is the oldest image row, tap 0 the leftmost column
  typedef pix_t [KSIZE-1:0][KSIZE-1:0] win_t;

  typedef logic [KSIZE-1:0][WEIGHT_REG_W-1:0] weights_t;

  typedef struct packed {
    orow_t out_row;
    ocol_t out_col;
    logic  frame_last;
  } pos_t;

  typedef struct packed {
    win_t win;
    pos_t pos;
  } q_entry_t;

endpackage

// ===== rtl/mc4_fifo.sv =====
// Short queue of window snapshots between the pixel front end and the MAC pipeline.
module mc4_fifo #(
  parameter int DEPTH = mc4_pkg::QDEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  mc4_pkg::q_entry_t    push_data,
  input  logic                 pop,
  output logic                 pop_valid,
  output mc4_pkg::q_entry_t    pop_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mc4_pkg::q_entry_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic do_pop;

  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

`include "multichannel_conv2d_4x4_assert.svh"

  `MC4_ASSERT_NOW(a_no_overflow, clk, rst, push, (count != CNT_W'(DEPTH)) || do_pop)
  `MC4_ASSERT_NOW(a_pop_valid_tracks_count, clk, rst, pop_valid, count <= CNT_W'(DEPTH))
  `MC4_ASSERT_NEXT(a_count_step, clk, rst, push && !do_pop, count == $past(count) + 1'b1)

endmodule

// ===== rtl/mc4_front.sv =====
// Pixel front end: raster counters, line memory, 4x4 window and result classification.
module mc4_front #(
  parameter int IMAGE_WIDTH  = mc4_pkg::DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = mc4_pkg::DEF_IMAGE_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  mc4_pkg::pix_t               s_tdata,
  input  logic [mc4_pkg::QCNT_W-1:0]  q_count,
  output logic                        push,
  output mc4_pkg::q_entry_t           push_data
);

  localparam int CW = $clog2(IMAGE_WIDTH);
  localparam int RW = $clog2(IMAGE_HEIGHT);
  localparam int PW = mc4_pkg::PIX_W;
  localparam int LW = (mc4_pkg::KSIZE - 1) * PW;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic          accept;

  // one word per column: three previous rows, oldest in the low bits
  logic [LW-1:0] line_mem [IMAGE_WIDTH];
  logic [LW-1:0] rd_word;

  logic          s1_valid;
  mc4_pkg::pix_t s1_pix;
  logic [CW-1:0] s1_col;
  logic [RW-1:0] s1_row;

  mc4_pkg::win_t win;
  mc4_pkg::win_t win_next;
  mc4_pkg::pix_t new_col [mc4_pkg::KSIZE];

  // room for every item in flight, counted before pops
  assign s_tready = (32'(q_count) + 32'(s1_valid)) < 32'(mc4_pkg::QDEPTH);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (col == CW'(IMAGE_WIDTH - 1)) begin
          col <= '0;
          row <= (row == RW'(IMAGE_HEIGHT - 1)) ? '0 : row + RW'(1);
        end else begin
          col <= col + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_word <= line_mem[col];
      s1_pix  <= s_tdata;
      s1_col  <= col;
      s1_row  <= row;
    end
    if (s1_valid) begin
      line_mem[s1_col] <= {s1_pix, rd_word[LW-1:PW]};
      win <= win_next;
    end
  end

  always_comb begin
    for (int i = 0; i < mc4_pkg::KSIZE - 1; i++) begin
      new_col[i] = rd_word[i*PW +: PW];
    end
    new_col[mc4_pkg::KSIZE-1] = s1_pix;
    for (int i = 0; i < mc4_pkg::KSIZE; i++) begin
      for (int j = 0; j < mc4_pkg::KSIZE - 1; j++) begin
        win_next[i][j] = win[i][j+1];
      end
      win_next[i][mc4_pkg::KSIZE-1] = new_col[i];
    end
  end

  assign push = s1_valid && (s1_row >= RW'(mc4_pkg::KSIZE - 1))
                         && (s1_col >= CW'(mc4_pkg::KSIZE - 1));

  always_comb begin
    push_data.win            = win_next;
    push_data.pos.out_row    = mc4_pkg::orow_t'(32'(s1_row) - 32'(mc4_pkg::KSIZE - 1));
    push_data.pos.out_col    = mc4_pkg::ocol_t'(32'(s1_col) - 32'(mc4_pkg::KSIZE - 1));
    push_data.pos.frame_last = (s1_row == RW'(IMAGE_HEIGHT - 1))
                            && (s1_col == CW'(IMAGE_WIDTH - 1));
  end

endmodule

// ===== rtl/mc4_mac.sv =====
// MAC pipeline: 48 products, two adder-tree stages and the output register.
module mc4_mac (
  input  logic                clk,
  input  logic                rst,
  input  mc4_pkg::weights_t   weights,
  input  logic                q_valid,
  input  mc4_pkg::q_entry_t   q_data,
  output logic                q_pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [31:0]         m_tdata,
  output logic                m_tlast
);

  localparam int K = mc4_pkg::KSIZE;
  localparam int C = mc4_pkg::NCHAN;
  localparam int NPROD = K * K * C;
  localparam int NPART = 8;
  localparam int PER_PART = NPROD / NPART;
  localparam int NHALF = 2;
  localparam int PER_HALF = NPART / NHALF;

  logic adv;

  mc4_pkg::prod_t prod      [NPROD];
  mc4_pkg::prod_t prod_next [NPROD];
  mc4_pkg::sum_t  part      [NPART];
  mc4_pkg::sum_t  part_next [NPART];
  mc4_pkg::sum_t  half      [NHALF];
  mc4_pkg::sum_t  half_next [NHALF];
  mc4_pkg::sum_t  sum;

  logic p_valid, b_valid, c_valid;
  mc4_pkg::pos_t p_pos, b_pos, c_pos, o_pos;

  // the whole pipeline moves unless the output beat is stuck
  assign adv   = !m_tvalid || m_tready;
  assign q_pop = q_valid && adv;

  always_comb begin
    for (int i = 0; i < K; i++) begin
      for (int j = 0; j < K; j++) begin
        for (int ch = 0; ch < C; ch++) begin
          prod_next[(i*K + j)*C + ch] =
            mc4_pkg::PROD_W'($signed({1'b0, q_data.win[i][j][ch*8 +: 8]}))
            * mc4_pkg::PROD_W'($signed(weights[i][j*8 +: 8]));
        end
      end
    end
  end

  always_comb begin
    for (int g = 0; g < NPART; g++) begin
      part_next[g] = '0;
      for (int k = 0; k < PER_PART; k++) begin
        part_next[g] = part_next[g] + mc4_pkg::SUM_W'(prod[g*PER_PART + k]);
      end
    end
    for (int h = 0; h < NHALF; h++) begin
      half_next[h] = '0;
      for (int k = 0; k < PER_HALF; k++) begin
        half_next[h] = half_next[h] + part[h*PER_HALF + k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid  <= 1'b0;
      b_valid  <= 1'b0;
      c_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      p_valid  <= q_valid;
      b_valid  <= p_valid;
      c_valid  <= b_valid;
      m_tvalid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod  <= prod_next;
      p_pos <= q_data.pos;
      part  <= part_next;
      b_pos <= p_pos;
      half  <= half_next;
      c_pos <= b_pos;
      sum   <= half[0] + half[1];
      o_pos <= c_pos;
    end
  end

  assign m_tdata = {1'b0, o_pos.out_col, o_pos.out_row, sum};
  assign m_tlast = o_pos.frame_last;

endmodule

// ===== rtl/multichannel_conv2d_4x4.sv =====
// Top level of the multichannel 4x4 convolution block.
//
//  channel  dir  handshake                 payload
//  s_*      in   s_tvalid / s_tready       s_tdata: one pixel, three 8-bit samples
//  m_*      out  m_tvalid / m_tready       m_tdata: window sum and position, m_tlast
//  cfg_*    in   cfg_we (no wait)          cfg_index / cfg_data: kernel weight rows
//
// Sustained rate is one pixel per clock while the output is not stalled; a result passes
// the front stage, queue, product register, two adder stages and output register.
// The line memory is one read and one write per pixel, on different columns.
// Reset zeroes the raster counters, the weights and the queue; the line memory
// and window are not cleared, since stale data never reaches a valid position.
// A stalled m_tready freezes the MAC pipeline; the four-entry queue absorbs window
// snapshots and s_tready drops once queued plus in-flight items fill it.
module multichannel_conv2d_4x4 #(
  parameter int IMAGE_WIDTH  = mc4_pkg::DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = mc4_pkg::DEF_IMAGE_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // sample_ch0 [7:0], sample_ch1 [15:8], sample_ch2 [23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // conv_sum [21:0], out_row [26:22], out_col [30:27], zero [31]
  output logic        m_tlast,   // frame_last
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  mc4_pkg::weights_t weights;

  logic                       push;
  mc4_pkg::q_entry_t          push_data;
  logic                       q_pop;
  logic                       q_valid;
  mc4_pkg::q_entry_t          q_data;
  logic [mc4_pkg::QCNT_W-1:0] q_count;

  // Weight rows: four signed bytes each, tap 0 in the low byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      weights <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mc4_pkg::REG_WEIGHTS_ROW0: weights[0] <= cfg_data;
        mc4_pkg::REG_WEIGHTS_ROW1: weights[1] <= cfg_data;
        mc4_pkg::REG_WEIGHTS_ROW2: weights[2] <= cfg_data;
        mc4_pkg::REG_WEIGHTS_ROW3: weights[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: count the raster, update line memory and window, flag valid positions.
  mc4_front #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  // Window snapshots wait here while the output side stalls.
  mc4_fifo #(
    .DEPTH (mc4_pkg::QDEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data),
    .count     (q_count)
  );

  // Back end: multiply, reduce and hold the result beat.
  mc4_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .weights  (weights),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
